[design/twsp_pkg.sv]
// ----------------------------------------------------------------------------
// Two-wheel speed controller package
// Shared widths, constants, codes and structs for the two-wheel encoder
// speed controller and its lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package twsp_pkg;

  // Field widths
  localparam int ANGLE_W    = 19;
  localparam int TARGET_W   = 24;
  localparam int SPEED_W    = 24;
  localparam int DT_W       = 16;
  localparam int DUTY_W     = 20;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int RAD_W      = 10;
  localparam int PER_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Internal widths
  localparam int DELTA_W  = 20;  // raw angle difference, signed
  localparam int ERR_W    = 25;  // speed error, signed Q.8
  localparam int INT_W    = 25;  // error integral, signed Q.8
  localparam int ISUM_W   = 32;  // integral before clamping
  localparam int PROD_W   = 57;  // general product register
  localparam int ACC_W    = 54;  // controller sum, Q.20 percent
  localparam int GD_W     = 26;  // derivative gain times one thousand
  localparam int PCT_W    = 7;   // whole percent, 0 to 100
  localparam int DIV_N_W  = 51;  // divider dividend width
  localparam int DIV_D_W  = 25;  // divider divisor width

  // Constants
  localparam int HALF_TURN  = 180000;
  localparam int FULL_TURN  = 360000;
  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
  localparam int PCT_SHIFT  = 20;
  localparam int PCT_MAX    = 100 * (1 << PCT_SHIFT);
  localparam int RECIP_SHIFT = 34;
  localparam logic [27:0] RECIP_100 = 28'd171798692;  // ceil(2^34 / 100)
  localparam int SPD_SHIFT  = 16;
  localparam int Q8_SHIFT   = 8;

  // Reset values of the registers
  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd614;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd123;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd2000;
  localparam logic [RAD_W-1:0]   RADIUS_RST = 10'd65;
  localparam logic [PER_W-1:0]   PERIOD_RST = 20'd100000;

  // Bridge direction codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_LIMIT  = 3'd3,
    CFG_RADIUS = 3'd4,
    CFG_PERIOD = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] limit;
    logic [RAD_W-1:0]   radius;
    logic [PER_W-1:0]   period;
  } cfg_t;

  // Command from the sequencer to one lane
  typedef struct packed {
    logic                       start;
    logic                       prime;
    logic                       ok;
    logic [ANGLE_W-1:0]         angle;
    logic signed [TARGET_W-1:0] target;
    logic [DT_W-1:0]            dt;
  } lane_cmd_t;

  // Result of one lane
  typedef struct packed {
    dir_e                      dir;
    logic [DUTY_W-1:0]         duty;
    logic signed [SPEED_W-1:0] speed;
  } lane_res_t;

endpackage

`default_nettype wire

[design/twsp_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divider that produces one quotient bit per cycle and pulses
// done when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module twsp_div
  import twsp_pkg::*;
#(
  parameter int DivW = DIV_N_W,
  parameter int DsrW = DIV_D_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DsrW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DivW-1:0]      quotient_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DsrW:0]   trial;
  logic            fits;

  // One shift-and-subtract step per cycle
  always_comb begin
    trial  = {rem_q, quo_q[DivW-1]};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DsrW'(trial - {1'b0, dsr_q}) : trial[DsrW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[design/twsp_lane.sv]
// ----------------------------------------------------------------------------
// Wheel lane
// Angle unwrapping, speed measurement and PID speed loop for one wheel,
// run as a sequence of multiply and divide steps over a shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module twsp_lane
  import twsp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire lane_cmd_t cmd_i,
  output logic           busy_o,
  output lane_res_t      res_o
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_MUL_R    = 15'b000000000000010,
    S_MUL_PI   = 15'b000000000000100,
    S_DIV_SPD  = 15'b000000000001000,
    S_WAIT_SPD = 15'b000000000010000,
    S_MUL_DT   = 15'b000000000100000,
    S_DIV_INT  = 15'b000000001000000,
    S_WAIT_INT = 15'b000000010000000,
    S_MUL_P    = 15'b000000100000000,
    S_MUL_I    = 15'b000001000000000,
    S_MUL_D    = 15'b000010000000000,
    S_DIV_D    = 15'b000100000000000,
    S_WAIT_D   = 15'b001000000000000,
    S_PCT      = 15'b010000000000000,
    S_DUTY     = 15'b100000000000000
  } state_e;

  localparam logic signed [DELTA_W-1:0] HalfS = DELTA_W'(HALF_TURN);
  localparam logic signed [DELTA_W-1:0] FullS = DELTA_W'(FULL_TURN);
  localparam logic signed [ACC_W-1:0]   PctMaxS = ACC_W'(PCT_MAX);

  // Division by one thousand: 2^20 = 1048 * 1000 + 576, and the small
  // remainder part is divided by a reciprocal, ceil(2^40 / 1000).
  localparam logic [10:0] K1kHiQ     = 11'd1048;
  localparam logic [9:0]  K1kHiR     = 10'd576;
  localparam logic [30:0] Recip1000  = 31'd1099511628;
  localparam int          Recip1kSh  = 40;

  state_e                     state_q, state_d;
  logic [ANGLE_W-1:0]         stored_q, stored_d;
  logic signed [INT_W-1:0]    integ_q, integ_d;
  logic signed [ERR_W-1:0]    prev_q, prev_d;
  logic signed [DELTA_W-1:0]  delta_q, delta_d;
  logic signed [TARGET_W-1:0] target_q, target_d;
  logic [DT_W-1:0]            dt_q, dt_d;
  logic [GD_W-1:0]            gd_q, gd_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       neg_q, neg_d;
  logic signed [ERR_W-1:0]    err_q, err_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [30:0]                kbase_q, kbase_d;
  logic [29:0]                krem_q, krem_d;
  lane_res_t                  res_q, res_d;

  logic signed [DELTA_W-1:0]  delta_raw;
  logic [PROD_W-1:0]          prod_abs;
  logic                       div_start;
  logic [DIV_N_W-1:0]         div_dividend;
  logic [DIV_D_W-1:0]         div_divisor;
  logic                       div_done;
  logic [DIV_N_W-1:0]         quot;
  logic signed [SPEED_W-1:0]  speed;
  logic signed [ISUM_W-1:0]   isum;
  logic signed [ISUM_W-1:0]   lim;
  logic signed [ERR_W:0]      ediff;
  logic signed [ACC_W-1:0]    qterm;
  logic signed [ACC_W-1:0]    clamped;
  logic [ACC_W-1:0]           mag;
  logic [PCT_W-1:0]           pct;
  logic [54:0]                duty_prod;
  logic [60:0]                kprod;
  logic [30:0]                q1k;

  // Shared divider of this lane
  twsp_div #(
    .DivW (DIV_N_W),
    .DsrW (DIV_D_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Step sequencer
  always_comb begin
    state_d      = state_q;
    stored_d     = stored_q;
    integ_d      = integ_q;
    prev_d       = prev_q;
    delta_d      = delta_q;
    target_d     = target_q;
    dt_d         = dt_q;
    gd_d         = gd_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    err_d        = err_q;
    acc_d        = acc_q;
    kbase_d      = kbase_q;
    krem_d       = krem_q;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    delta_raw = $signed({1'b0, cmd_i.angle}) - $signed({1'b0, stored_q});
    prod_abs  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    speed     = '0;
    isum      = '0;
    lim       = $signed({{(ISUM_W - LIMIT_W - Q8_SHIFT){1'b0}}, cfg_i.limit,
                         {Q8_SHIFT{1'b0}}});
    ediff     = $signed({err_q[ERR_W-1], err_q}) - $signed({prev_q[ERR_W-1], prev_q});
    qterm     = neg_q ? -ACC_W'($signed({1'b0, quot})) : ACC_W'($signed({1'b0, quot}));
    clamped   = acc_q;
    mag       = '0;
    pct       = '0;
    duty_prod = {27'd0, prod_q[27:0]} * {27'd0, RECIP_100};
    kprod     = {31'd0, krem_q} * {30'd0, Recip1000};
    q1k       = kbase_q + 31'(kprod >> Recip1kSh);

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.start || cmd_i.prime) begin
          if (cmd_i.ok) begin
            stored_d = cmd_i.angle;
          end
          if (cmd_i.start) begin
            // Unwrap the angle step into half a turn either way
            delta_d = '0;
            if (cmd_i.ok) begin
              if (delta_raw > HalfS) begin
                delta_d = delta_raw - FullS;
              end else if (delta_raw < -HalfS) begin
                delta_d = delta_raw + FullS;
              end else begin
                delta_d = delta_raw;
              end
            end
            target_d = cmd_i.target;
            dt_d     = cmd_i.dt;
            gd_d     = GD_W'({10'd0, cfg_i.gain_d} * 26'd1000);
            res_d    = '{dir: DIR_STOP, duty: '0, speed: '0};
            if (cmd_i.dt != '0) begin
              state_d = S_MUL_R;
            end
          end
        end
      end
      S_MUL_R: begin
        prod_d  = PROD_W'(delta_q * $signed({1'b0, cfg_i.radius}));
        state_d = S_MUL_PI;
      end
      S_MUL_PI: begin
        prod_d  = PROD_W'($signed(prod_q[30:0]) * $signed({1'b0, TWO_PI_Q24}));
        state_d = S_DIV_SPD;
      end
      S_DIV_SPD: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(prod_abs >> SPD_SHIFT);
        div_divisor  = {9'd0, dt_q} * 25'd360;
        neg_d        = prod_q[PROD_W-1];
        state_d      = S_WAIT_SPD;
      end
      S_WAIT_SPD: begin
        if (div_done) begin
          // Saturate the measured speed to the field range
          if (quot >= DIV_N_W'(1 << (SPEED_W - 1))) begin
            speed = neg_q ? $signed({1'b1, {(SPEED_W - 1){1'b0}}})
                          : $signed({1'b0, {(SPEED_W - 1){1'b1}}});
          end else begin
            speed = neg_q ? -$signed(quot[SPEED_W-1:0]) : $signed(quot[SPEED_W-1:0]);
          end
          res_d.speed = speed;
          err_d   = ERR_W'(target_q) - ERR_W'(speed);
          state_d = S_MUL_DT;
        end
      end
      S_MUL_DT: begin
        prod_d  = PROD_W'(err_q * $signed({1'b0, dt_q}));
        state_d = S_DIV_INT;
      end
      S_DIV_INT: begin
        // Split the magnitude at bit 20 for the division by one thousand
        kbase_d = 31'(prod_abs[39:20] * K1kHiQ);
        krem_d  = 30'(prod_abs[39:20] * K1kHiR) + {10'd0, prod_abs[19:0]};
        neg_d   = prod_q[PROD_W-1];
        state_d = S_WAIT_INT;
      end
      S_WAIT_INT: begin
        // Accumulate and clamp the integral
        isum = ISUM_W'(integ_q) + (neg_q ? -$signed({1'b0, q1k})
                                         : $signed({1'b0, q1k}));
        if (isum > lim) begin
          isum = lim;
        end else if (isum < -lim) begin
          isum = -lim;
        end
        integ_d = INT_W'(isum);
        state_d = S_MUL_P;
      end
      S_MUL_P: begin
        acc_d   = ACC_W'(err_q * $signed({1'b0, cfg_i.gain_p}));
        state_d = S_MUL_I;
      end
      S_MUL_I: begin
        acc_d   = acc_q + ACC_W'(integ_q * $signed({1'b0, cfg_i.gain_i}));
        state_d = S_MUL_D;
      end
      S_MUL_D: begin
        prod_d  = PROD_W'(ediff * $signed({1'b0, gd_q}));
        prev_d  = err_q;
        state_d = S_DIV_D;
      end
      S_DIV_D: begin
        div_start    = 1'b1;
        div_dividend = prod_abs[DIV_N_W-1:0];
        div_divisor  = {9'd0, dt_q};
        neg_d        = prod_q[PROD_W-1];
        state_d      = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (div_done) begin
          acc_d   = acc_q + qterm;
          state_d = S_PCT;
        end
      end
      S_PCT: begin
        // Clamp to full scale and truncate to whole percent
        if (acc_q > PctMaxS) begin
          clamped = PctMaxS;
        end else if (acc_q < -PctMaxS) begin
          clamped = -PctMaxS;
        end
        mag = clamped[ACC_W-1] ? ACC_W'(-clamped) : ACC_W'(clamped);
        pct = PCT_W'(mag >> PCT_SHIFT);
        if (pct == '0) begin
          res_d.dir = DIR_STOP;
        end else if (clamped[ACC_W-1]) begin
          res_d.dir = DIR_REV;
        end else begin
          res_d.dir = DIR_FWD;
        end
        prod_d  = PROD_W'({{(PROD_W - PCT_W){1'b0}}, pct} * {{(PROD_W - PER_W){1'b0}},
                                                            cfg_i.period});
        state_d = S_DUTY;
      end
      S_DUTY: begin
        res_d.duty = DUTY_W'(duty_prod >> RECIP_SHIFT);
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      stored_q <= '0;
      integ_q  <= '0;
      prev_q   <= '0;
      res_q    <= '{dir: DIR_STOP, duty: '0, speed: '0};
    end else begin
      state_q  <= state_d;
      stored_q <= stored_d;
      integ_q  <= integ_d;
      prev_q   <= prev_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    target_q <= target_d;
    dt_q     <= dt_d;
    gd_q     <= gd_d;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    err_q    <= err_d;
    acc_q    <= acc_d;
    kbase_q  <= kbase_d;
    krem_q   <= krem_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

endmodule

`default_nettype wire

[design/two_wheel_encoder_speed_pid.sv]
// ----------------------------------------------------------------------------
// Two-wheel encoder speed PID controller
// Measures both wheel speeds from absolute encoder angles and drives each
// H-bridge from a clamped PID speed loop.
// ----------------------------------------------------------------------------
// Each sample tick is one input transaction and gives one output transaction
// carrying both wheels. The two wheels run in their own lanes side by side,
// and each lane steps through two divisions by the elapsed time in its own
// restoring divider, the division by one thousand being done by a reciprocal
// multiplication; a halt tick, the first (priming) tick and a tick with zero
// elapsed time skip these steps. A new tick is taken once the previous result
// has been placed in the output register, even while it still waits there for
// the receiver. Configuration writes take effect at once and must only be made
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wheel_encoder_speed_pid
  import twsp_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data_i,
  // Sample input
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ANGLE_W-1:0]          left_angle_mdeg_i,
  input  wire logic [ANGLE_W-1:0]          right_angle_mdeg_i,
  input  wire logic                        left_read_ok_i,
  input  wire logic                        right_read_ok_i,
  input  wire logic signed [TARGET_W-1:0]  left_target_i,
  input  wire logic signed [TARGET_W-1:0]  right_target_i,
  input  wire logic [DT_W-1:0]             elapsed_ms_i,
  input  wire logic                        halt_i,
  // Result output
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       left_direction_o,
  output logic [DUTY_W-1:0]                left_duty_ns_o,
  output logic [1:0]                       right_direction_o,
  output logic [DUTY_W-1:0]                right_duty_ns_o,
  output logic signed [SPEED_W-1:0]        left_speed_o,
  output logic signed [SPEED_W-1:0]        right_speed_o
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_EMIT = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;
  cfg_t       cfg_q;
  logic       primed_q, primed_d;
  logic       zero_q, zero_d;
  logic       out_valid_q, out_valid_d;
  lane_res_t  out_l_q, out_l_d;
  lane_res_t  out_r_q, out_r_d;

  logic       accept;
  lane_cmd_t  cmd_l, cmd_r;
  lane_res_t  res_l, res_r;
  logic       busy_l, busy_r;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
                 limit: LIMIT_RST, radius: RADIUS_RST, period: PERIOD_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P: cfg_q.gain_p <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I: cfg_q.gain_i <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D: cfg_q.gain_d <= cfg_data_i[GAIN_W-1:0];
        CFG_LIMIT:  cfg_q.limit  <= cfg_data_i[LIMIT_W-1:0];
        CFG_RADIUS: cfg_q.radius <= cfg_data_i[RAD_W-1:0];
        CFG_PERIOD: cfg_q.period <= cfg_data_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Lane commands: halt leaves all state alone, the first tick only primes
  always_comb begin
    cmd_l.start  = accept && !halt_i && primed_q;
    cmd_l.prime  = accept && !halt_i && !primed_q;
    cmd_l.ok     = left_read_ok_i;
    cmd_l.angle  = left_angle_mdeg_i;
    cmd_l.target = left_target_i;
    cmd_l.dt     = elapsed_ms_i;
    cmd_r.start  = cmd_l.start;
    cmd_r.prime  = cmd_l.prime;
    cmd_r.ok     = right_read_ok_i;
    cmd_r.angle  = right_angle_mdeg_i;
    cmd_r.target = right_target_i;
    cmd_r.dt     = elapsed_ms_i;
  end

  twsp_lane u_lane_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd_l),
    .busy_o (busy_l),
    .res_o  (res_l)
  );

  twsp_lane u_lane_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd_r),
    .busy_o (busy_r),
    .res_o  (res_r)
  );

  // Merge both lanes into the output register
  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          zero_d = halt_i || !primed_q;
          if (!halt_i) begin
            primed_d = 1'b1;
          end
          state_d = (halt_i || !primed_q) ? T_EMIT : T_RUN;
        end
      end
      T_RUN: begin
        if (!busy_l && !busy_r) begin
          state_d = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (zero_q) begin
            out_l_d = '{dir: DIR_STOP, duty: '0, speed: '0};
            out_r_d = '{dir: DIR_STOP, duty: '0, speed: '0};
          end else begin
            out_l_d = res_l;
            out_r_d = res_r;
          end
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      primed_q    <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_l_q <= out_l_d;
    out_r_q <= out_r_d;
  end

  assign out_valid_o       = out_valid_q;
  assign left_direction_o  = out_l_q.dir;
  assign left_duty_ns_o    = out_l_q.duty;
  assign left_speed_o      = out_l_q.speed;
  assign right_direction_o = out_r_q.dir;
  assign right_duty_ns_o   = out_r_q.duty;
  assign right_speed_o     = out_r_q.speed;

  // A new transaction is only taken when both lanes have finished
  a_ready_lanes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!busy_l && !busy_r))
    else $error("input taken while a lane is busy");

  // A halted tick never starts the lanes
  a_halt_no_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && halt_i) |=> (!busy_l && !busy_r))
    else $error("lane started on a halted tick");

  // A stopped bridge has no high time
  a_left_stop_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && left_direction_o == DIR_STOP) |-> (left_duty_ns_o == '0))
    else $error("left duty set while stopped");

  a_right_stop_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && right_direction_o == DIR_STOP) |-> (right_duty_ns_o == '0))
    else $error("right duty set while stopped");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-wheel speed controller testbench
// Drives sample ticks through the valid/ready input and checks every result
// transaction against a cycle-free predictor of the speed measurement and
// the clamped PID loop. Stimulus is a directed table followed by random
// ticks over several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import twsp_pkg::*;

  typedef struct packed {
    logic [ANGLE_W-1:0]         l_ang;
    logic [ANGLE_W-1:0]         r_ang;
    logic                       l_ok;
    logic                       r_ok;
    logic signed [TARGET_W-1:0] l_tgt;
    logic signed [TARGET_W-1:0] r_tgt;
    logic [DT_W-1:0]            dt;
    logic                       halt;
  } tick_t;

  typedef struct packed {
    logic [1:0]                l_dir;
    logic [DUTY_W-1:0]         l_duty;
    logic [1:0]                r_dir;
    logic [DUTY_W-1:0]         r_duty;
    logic signed [SPEED_W-1:0] l_spd;
    logic signed [SPEED_W-1:0] r_spd;
  } drive_t;

  // Directed table row: the expected result is used only when fixed is set.
  typedef struct packed {
    tick_t  tick;
    logic   fixed;
    drive_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tick_t drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  drive_t got;

  always #1 clk_i = ~clk_i;

  two_wheel_encoder_speed_pid dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .left_angle_mdeg_i(drv.l_ang), .right_angle_mdeg_i(drv.r_ang),
    .left_read_ok_i(drv.l_ok), .right_read_ok_i(drv.r_ok),
    .left_target_i(drv.l_tgt), .right_target_i(drv.r_tgt),
    .elapsed_ms_i(drv.dt), .halt_i(drv.halt),
    .out_valid_o, .out_ready_i,
    .left_direction_o(got.l_dir), .left_duty_ns_o(got.l_duty),
    .right_direction_o(got.r_dir), .right_duty_ns_o(got.r_duty),
    .left_speed_o(got.l_spd), .right_speed_o(got.r_spd)
  );

  // Predictor copy of the registers and the loop state.
  longint unsigned kp, ki, kd, ilim, radius, period;
  logic [ANGLE_W-1:0] last_ang [2];
  longint integ_acc [2];
  longint prev_err [2];
  bit primed;

  drive_t pending_drive [$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // One wheel of the speed loop; updates the predictor state.
  function automatic void wheel_loop(input int w, input logic [ANGLE_W-1:0] ang,
                                     input logic ok,
                                     input logic signed [TARGET_W-1:0] tgt,
                                     input longint dt, output logic [1:0] dir,
                                     output logic [DUTY_W-1:0] duty,
                                     output logic signed [SPEED_W-1:0] spd);
    longint delta, speed, err, lim, integ, sum, pct;
    delta = 0;
    dir = DIR_STOP;
    duty = '0;
    spd = '0;
    if (ok) begin
      delta = longint'(ang) - longint'(last_ang[w]);
      if (delta > HALF_TURN) delta -= FULL_TURN;
      if (delta < -HALF_TURN) delta += FULL_TURN;
      last_ang[w] = ang;
    end
    if (dt == 0) return;
    speed = (delta * longint'(radius) * 64'sd105414357) / (360 * dt * 65536);
    speed = clip(speed, -8388608, 8388607);
    spd = speed[SPEED_W-1:0];
    err = longint'(tgt) - speed;
    lim = longint'(ilim) * 256;
    integ = clip(integ_acc[w] + (err * dt) / 1000, -lim, lim);
    integ_acc[w] = integ;
    sum = longint'(kp) * err + longint'(ki) * integ
        + (longint'(kd) * (err - prev_err[w]) * 1000) / dt;
    prev_err[w] = err;
    sum = clip(sum, -longint'(PCT_MAX), longint'(PCT_MAX));
    pct = sum / (64'sd1 << PCT_SHIFT);
    if (pct > 0) dir = DIR_FWD;
    else if (pct < 0) begin
      dir = DIR_REV;
      pct = -pct;
    end
    duty = DUTY_W'((longint'(pct) * longint'(period)) / 100);
  endfunction

  function automatic drive_t predict_drive(tick_t t);
    drive_t d;
    d = '0;
    if (t.halt) return d;
    if (!primed) begin
      if (t.l_ok) last_ang[0] = t.l_ang;
      if (t.r_ok) last_ang[1] = t.r_ang;
      primed = 1'b1;
      return d;
    end
    wheel_loop(0, t.l_ang, t.l_ok, t.l_tgt, t.dt, d.l_dir, d.l_duty, d.l_spd);
    wheel_loop(1, t.r_ang, t.r_ok, t.r_tgt, t.dt, d.r_dir, d.r_duty, d.r_spd);
    return d;
  endfunction

  // Register write on the plain port, mirrored into the predictor.
  task automatic write_reg(input cfg_idx_e idx, input longint unsigned val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN_P: kp = val & 16'hFFFF;
      CFG_GAIN_I: ki = val & 16'hFFFF;
      CFG_GAIN_D: kd = val & 16'hFFFF;
      CFG_LIMIT:  ilim = val & 16'hFFFF;
      CFG_RADIUS: radius = val & 10'h3FF;
      CFG_PERIOD: period = val & 20'hFFFFF;
      default: ;
    endcase
  endtask

  // Offer one transaction; the expectation is queued on acceptance.
  task automatic send_tick(input tick_t t, input bit fixed, input drive_t want);
    drive_t p;
    in_valid_i <= 1'b1;
    drv <= t;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_drive(t);
    if (fixed && p !== want) begin
      $display("%0t directed row disagrees: expected %h predicted %h", $time, want, p);
      errors++;
    end
    pending_drive.push_back(fixed ? want : p);
  endtask

  task automatic drain;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic tick_t rand_tick(bit wide);
    tick_t t;
    t.l_ang = ($urandom_range(0, 15) == 0) ? ANGLE_W'($urandom)
                                            : ANGLE_W'($urandom_range(0, 359999));
    t.r_ang = ($urandom_range(0, 15) == 0) ? ANGLE_W'($urandom)
                                            : ANGLE_W'($urandom_range(0, 359999));
    t.l_ok = $urandom_range(0, 9) != 0;
    t.r_ok = $urandom_range(0, 9) != 0;
    t.l_tgt = wide ? TARGET_W'($urandom) : TARGET_W'($signed($urandom_range(0, 400000)) - 200000);
    t.r_tgt = wide ? TARGET_W'($urandom) : TARGET_W'($signed($urandom_range(0, 400000)) - 200000);
    case ($urandom_range(0, 9))
      0:       t.dt = '0;
      1:       t.dt = DT_W'($urandom);
      2:       t.dt = DT_W'($urandom_range(1, 3));
      default: t.dt = DT_W'($urandom_range(5, 30));
    endcase
    t.halt = $urandom_range(0, 19) == 0;
    return t;
  endfunction

  // Stimulus.
  initial begin
    row_t rows [$];
    drive_t z;
    int n;
    kp = GAIN_P_RST; ki = GAIN_I_RST; kd = GAIN_D_RST;
    ilim = LIMIT_RST; radius = RADIUS_RST; period = PERIOD_RST;
    for (int w = 0; w < 2; w++) begin
      last_ang[w] = '0; integ_acc[w] = 0; prev_err[w] = 0;
    end
    primed = 1'b0;
    z = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Halt before priming, priming tick, then the corner cases.
    rows.push_back('{'{19'd100, 19'd200, 1'b1, 1'b1, 24'sd0, 24'sd0, 16'd10, 1'b1},
                     1'b1, z});
    rows.push_back('{'{19'd359999, 19'd0, 1'b1, 1'b1, 24'sd0, 24'sd0, 16'd10, 1'b0},
                     1'b1, z});
    rows.push_back('{'{19'd0, 19'd359999, 1'b1, 1'b1, 24'sd25600, -24'sd25600, 16'd10,
                       1'b0}, 1'b0, z});
    rows.push_back('{'{19'd179999, 19'd180001, 1'b1, 1'b1, 24'sh7FFFFF, 24'sh800000,
                       16'd10, 1'b0}, 1'b0, z});
    rows.push_back('{'{19'd0, 19'd0, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'd0, 1'b0}, 1'b1, z});
    rows.push_back('{'{19'h7FFFF, 19'h7FFFF, 1'b1, 1'b1, 24'sd100, -24'sd100, 16'd1,
                       1'b0}, 1'b0, z});
    rows.push_back('{'{19'd0, 19'd0, 1'b1, 1'b1, 24'sd0, 24'sd0, 16'hFFFF, 1'b0},
                     1'b0, z});
    rows.push_back('{'{19'd90000, 19'd270000, 1'b0, 1'b0, -24'sd5000, 24'sd5000, 16'd10,
                       1'b0}, 1'b0, z});
    rows.push_back('{'{19'd90000, 19'd270000, 1'b1, 1'b1, 24'sd0, 24'sd0, 16'd10, 1'b1},
                     1'b1, z});
    rows.push_back('{'{19'd91000, 19'd269000, 1'b1, 1'b1, 24'sd3000, -24'sd3000, 16'd10,
                       1'b0}, 1'b0, z});
    foreach (rows[i]) send_tick(rows[i].tick, rows[i].fixed, rows[i].want);
    in_valid_i <= 1'b0;
    drain();

    // Extreme register settings with a derivative term.
    write_reg(CFG_GAIN_P, 65535); write_reg(CFG_GAIN_I, 65535);
    write_reg(CFG_GAIN_D, 65535); write_reg(CFG_LIMIT, 65535);
    write_reg(CFG_RADIUS, 1023); write_reg(CFG_PERIOD, 1000000);
    for (int i = 0; i < 6; i++) send_tick(rand_tick(1'b1), 1'b0, z);
    in_valid_i <= 1'b0;
    drain();
    write_reg(CFG_GAIN_P, 0); write_reg(CFG_GAIN_I, 0); write_reg(CFG_GAIN_D, 0);
    write_reg(CFG_LIMIT, 0); write_reg(CFG_RADIUS, 1); write_reg(CFG_PERIOD, 1);
    for (int i = 0; i < 5; i++) send_tick(rand_tick(1'b1), 1'b0, z);
    in_valid_i <= 1'b0;
    drain();

    // Random phases, each with its own settings; bursts with random gaps.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_GAIN_P, ph == 0 ? 614 : $urandom_range(0, 65535));
      write_reg(CFG_GAIN_I, ph == 0 ? 123 : $urandom_range(0, 65535));
      write_reg(CFG_GAIN_D, $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535));
      write_reg(CFG_LIMIT, $urandom_range(0, 65535));
      write_reg(CFG_RADIUS, $urandom_range(1, 1023));
      write_reg(CFG_PERIOD, $urandom_range(1, 1000000));
      if (ph == 2) hold_off = 1'b1;
      n = 0;
      while (n < 100) begin
        for (int b = $urandom_range(1, 8); b > 0 && n < 100; b--) begin
          send_tick(rand_tick($urandom_range(0, 3) == 0), 1'b0, z);
          n++;
        end
        if ($urandom_range(0, 2) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 300)) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      drain();
    end
    stim_done = 1'b1;
  end

  // Receiver: stall pattern plus one long hold-off.
  initial begin
    int k;
    k = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      k++;
      out_ready_i <= ((k / 700) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drive.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        errors++;
      end else begin
        want = pending_drive.pop_front();
        if (got.l_dir !== want.l_dir || got.l_duty !== want.l_duty ||
            got.r_dir !== want.r_dir || got.r_duty !== want.r_duty ||
            got.l_spd !== want.l_spd || got.r_spd !== want.r_spd) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    if (errors == 0 && pending_drive.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
